// ----- design/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg: shared types and constants for the Morse code keyer
// Letter pattern table, field widths and sequencer state encoding.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W        = 8;
  localparam int DOT_W         = 14;
  localparam int UNITS_W       = 3;
  localparam int DUR_W         = 17;
  localparam int PAT_W         = 16;
  localparam int MAX_CODE_BITS = 32;
  localparam int CODE_BITS_DEF = 16;

  localparam logic [DOT_W-1:0]   DOT_TIME_RST = 14'd500;
  localparam logic [UNITS_W-1:0] UNITS_GAP    = 3'd1;
  localparam logic [UNITS_W-1:0] UNITS_LETTER = 3'd3;
  localparam logic [UNITS_W-1:0] UNITS_WORD   = 3'd7;
  localparam logic [UNITS_W-1:0] UNITS_MAX    = 3'd7;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPACE,
    ST_FINAL
  } state_t;

  // Patterns are top aligned; runs of ones are marks, single zeros are gaps
  function automatic logic [PAT_W-1:0] letter_pattern(input logic [4:0] idx);
    logic [PAT_W-1:0] pat;
    case (idx)
      5'd0:    pat = 16'hB800;
      5'd1:    pat = 16'hEA80;
      5'd2:    pat = 16'hEBA0;
      5'd3:    pat = 16'hEA00;
      5'd4:    pat = 16'h8000;
      5'd5:    pat = 16'hAE80;
      5'd6:    pat = 16'hEE80;
      5'd7:    pat = 16'hAA00;
      5'd8:    pat = 16'hA000;
      5'd9:    pat = 16'hBBB8;
      5'd10:   pat = 16'hEB80;
      5'd11:   pat = 16'hBA80;
      5'd12:   pat = 16'hEE00;
      5'd13:   pat = 16'hE800;
      5'd14:   pat = 16'hEEE0;
      5'd15:   pat = 16'hBBA0;
      5'd16:   pat = 16'hEEB8;
      5'd17:   pat = 16'hBA00;
      5'd18:   pat = 16'hA800;
      5'd19:   pat = 16'hE000;
      5'd20:   pat = 16'hAE00;
      5'd21:   pat = 16'hAB80;
      5'd22:   pat = 16'hBB80;
      5'd23:   pat = 16'hEAE0;
      5'd24:   pat = 16'hEBB8;
      5'd25:   pat = 16'hEEA0;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// ----- design/morse_code_keyer.sv -----
// ----------------------------------------------------------------------------
// morse_code_keyer: ASCII character to Morse LED segments
// Scans the letter pattern one bit per cycle and emits on/off segments.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_character
// out     | output    | out_valid/out_stall| out_led_on, out_dot_units,
//         |           |                    | out_duration_ms, out_last
// cfg     | input     | cfg_we             | cfg_wdata (dot time in ms)
//
// A letter holds in_stall after its transfer while the pattern is scanned, one
// pattern bit per cycle through the shift register, and while the closing off
// segment goes out, preceded by the last mark if the pattern ends in one. A
// space holds in_stall while its word gap goes out; other bytes not at all.
// Output stalls hold the scan only on a bit that has a segment to emit. Reset
// (synchronous, active low) sets the dot time to 500 ms and idles.
module morse_code_keyer #(
  parameter int CODE_BITS = mck_pkg::CODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mck_pkg::DOT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mck_pkg::CHAR_W-1:0]    in_character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_led_on,
  output logic [mck_pkg::UNITS_W-1:0]   out_dot_units,
  output logic [mck_pkg::DUR_W-1:0]     out_duration_ms,
  output logic                          out_last
);

  localparam int CNT_W = $clog2(CODE_BITS);

  mck_pkg::state_t               state_r, state_nxt;
  logic [CODE_BITS-1:0]          shift_r, shift_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [mck_pkg::UNITS_W-1:0]   run_r, run_nxt;
  logic                          gap_r, gap_nxt;
  logic [mck_pkg::DOT_W-1:0]     dot_time_r;

  logic                          out_valid_r;
  logic                          led_on_r;
  logic [mck_pkg::UNITS_W-1:0]   units_r;
  logic [mck_pkg::DUR_W-1:0]     dur_r;
  logic                          last_r;

  logic                          slot_free;
  logic                          emit;
  logic                          seg_on;
  logic [mck_pkg::UNITS_W-1:0]   seg_units;
  logic                          seg_last;
  logic                          in_xfer;
  logic [mck_pkg::CHAR_W-1:0]    lower;
  logic                          is_letter;
  logic [4:0]                    letter_idx;
  logic [mck_pkg::MAX_CODE_BITS-1:0] pat_wide;
  logic                          bit_msb;

  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != mck_pkg::ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  // folding case: setting bit 5 maps upper to lower case
  assign lower      = in_character | mck_pkg::CHAR_CASE;
  assign is_letter  = (lower >= mck_pkg::CHAR_LOWER_A) && (lower <= mck_pkg::CHAR_LOWER_Z);
  assign letter_idx = 5'(lower - mck_pkg::CHAR_LOWER_A);
  assign pat_wide   = {mck_pkg::letter_pattern(letter_idx),
                       {(mck_pkg::MAX_CODE_BITS - mck_pkg::PAT_W){1'b0}}};
  assign bit_msb    = shift_r[CODE_BITS-1];

  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    gap_nxt   = gap_r;
    emit      = 1'b0;
    seg_on    = 1'b0;
    seg_units = mck_pkg::UNITS_GAP;
    seg_last  = 1'b0;
    case (state_r)
      mck_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_character == mck_pkg::CHAR_SPACE) begin
            state_nxt = mck_pkg::ST_SPACE;
          end else if (is_letter) begin
            state_nxt = mck_pkg::ST_SCAN;
            shift_nxt = pat_wide[mck_pkg::MAX_CODE_BITS-1 -: CODE_BITS];
            cnt_nxt   = '0;
            run_nxt   = '0;
            gap_nxt   = 1'b0;
          end
        end
      end
      mck_pkg::ST_SCAN: begin
        if (bit_msb) begin
          emit      = gap_r;
          seg_on    = 1'b0;
          seg_units = mck_pkg::UNITS_GAP;
        end else begin
          emit      = (run_r != '0);
          seg_on    = 1'b1;
          seg_units = run_r;
        end
        if (!emit || slot_free) begin
          shift_nxt = shift_r << 1;
          cnt_nxt   = cnt_r + 1'b1;
          if (bit_msb) begin
            gap_nxt = 1'b0;
            if (run_r != mck_pkg::UNITS_MAX) begin
              run_nxt = run_r + 1'b1;
            end
          end else if (run_r != '0) begin
            run_nxt = '0;
            gap_nxt = 1'b1;
          end
          if (cnt_r == CNT_W'(CODE_BITS - 1)) begin
            state_nxt = mck_pkg::ST_FINAL;
          end
        end else begin
          emit = 1'b0;
        end
      end
      mck_pkg::ST_SPACE: begin
        seg_units = mck_pkg::UNITS_WORD;
        seg_last  = 1'b1;
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = mck_pkg::ST_IDLE;
        end
      end
      mck_pkg::ST_FINAL: begin
        // a mark still open at the end of the pattern goes out first
        if (run_r != '0) begin
          seg_on    = 1'b1;
          seg_units = run_r;
          if (slot_free) begin
            emit    = 1'b1;
            run_nxt = '0;
          end
        end else begin
          seg_units = mck_pkg::UNITS_LETTER;
          seg_last  = 1'b1;
          if (slot_free) begin
            emit      = 1'b1;
            state_nxt = mck_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = mck_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mck_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      dot_time_r  <= mck_pkg::DOT_TIME_RST;
      run_r       <= '0;
      gap_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      gap_r   <= gap_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        dot_time_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (emit) begin
      led_on_r <= seg_on;
      units_r  <= seg_units;
      dur_r    <= mck_pkg::DUR_W'(seg_units) * mck_pkg::DUR_W'(dot_time_r);
      last_r   <= seg_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = led_on_r;
  assign out_dot_units   = units_r;
  assign out_duration_ms = dur_r;
  assign out_last        = last_r;

endmodule

// ----- design/mck_checker.sv -----
// ----------------------------------------------------------------------------
// mck_checker: port-level checks for the Morse code keyer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mck_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_led_on,
  input logic [mck_pkg::UNITS_W-1:0] out_dot_units,
  input logic [mck_pkg::DUR_W-1:0]   out_duration_ms,
  input logic                        out_last
);

  // a stalled segment stays offered and unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dot_units)
      && $stable(out_duration_ms) && $stable(out_led_on) && $stable(out_last))
    else $error("stalled segment changed");

  // only dot, dash and the two closing lengths exist
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dot_units == 3'd1 || out_dot_units == 3'd3
      || out_dot_units == 3'd7)
    else $error("bad segment length");

  // the closing segment of a character is always dark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_led_on)
    else $error("last segment lit");

  // a word space is a single dark segment that closes its character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dot_units == 3'd7 |-> out_last && !out_led_on)
    else $error("word space malformed");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_led_on      (out_led_on),
  .out_dot_units   (out_dot_units),
  .out_duration_ms (out_duration_ms),
  .out_last        (out_last)
);

// ----- tb/morse_seg_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse_seg_checker: segment predictor and scoreboard for the Morse keyer
// Watches the character, segment and dot time ports. Every character transfer
// is expanded into the LED segments it should produce. Every segment transfer
// is compared field by field with the oldest predicted segment.
// ----------------------------------------------------------------------------
module morse_seg_checker #(
  parameter int CODE_BITS = mck_pkg::CODE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mck_pkg::DOT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [mck_pkg::CHAR_W-1:0]  in_character,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_led_on,
  input  logic [mck_pkg::UNITS_W-1:0] out_dot_units,
  input  logic [mck_pkg::DUR_W-1:0]   out_duration_ms,
  input  logic                        out_last,
  output int                          n_fail,
  output int                          n_pending
);

  typedef struct {
    logic                        led_on;
    logic [mck_pkg::UNITS_W-1:0] dot_units;
    logic [mck_pkg::DUR_W-1:0]   duration_ms;
    logic                        last;
  } segment_t;

  // A..Z, top aligned: ones are marks, zeros are spaces
  localparam logic [mck_pkg::PAT_W-1:0] MORSE_TABLE [26] = '{
    16'hB800, 16'hEA80, 16'hEBA0, 16'hEA00, 16'h8000, 16'hAE80, 16'hEE80,
    16'hAA00, 16'hA000, 16'hBBB8, 16'hEB80, 16'hBA80, 16'hEE00, 16'hE800,
    16'hEEE0, 16'hBBA0, 16'hEEB8, 16'hBA00, 16'hA800, 16'hE000, 16'hAE00,
    16'hAB80, 16'hBB80, 16'hEAE0, 16'hEBB8, 16'hEEA0
  };

  localparam logic [mck_pkg::CHAR_W-1:0] CHAR_UPPER_A =
    mck_pkg::CHAR_LOWER_A - mck_pkg::CHAR_CASE;
  localparam logic [mck_pkg::CHAR_W-1:0] CHAR_UPPER_Z =
    mck_pkg::CHAR_LOWER_Z - mck_pkg::CHAR_CASE;

  logic [mck_pkg::DOT_W-1:0] dot_ms;
  segment_t                  expected_segs[$];

  function automatic void add_segment(input logic on,
                                      input logic [mck_pkg::UNITS_W-1:0] units,
                                      input logic is_last);
    segment_t s;
    s.led_on      = on;
    s.dot_units   = units;
    s.duration_ms = mck_pkg::DUR_W'(32'(units) * 32'(dot_ms));
    s.last        = is_last;
    expected_segs.push_back(s);
  endfunction

  function automatic void predict_segments(input logic [mck_pkg::CHAR_W-1:0] c);
    logic [mck_pkg::PAT_W-1:0]   pat;
    logic [mck_pkg::UNITS_W-1:0] run;
    logic                        gap_pending;
    logic                        bit_v;
    int                          idx;
    idx         = -1;
    run         = '0;
    gap_pending = 1'b0;
    if (c >= mck_pkg::CHAR_LOWER_A && c <= mck_pkg::CHAR_LOWER_Z) begin
      idx = int'(c - mck_pkg::CHAR_LOWER_A);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      idx = int'(c - CHAR_UPPER_A);
    end else if (c == mck_pkg::CHAR_SPACE) begin
      add_segment(1'b0, mck_pkg::UNITS_WORD, 1'b1);
    end
    if (idx >= 0) begin
      pat = MORSE_TABLE[idx];
      for (int i = 0; i < CODE_BITS; i++) begin
        bit_v = (i < mck_pkg::PAT_W) ? pat[mck_pkg::PAT_W-1-i] : 1'b0;
        if (bit_v) begin
          if (gap_pending) begin
            add_segment(1'b0, mck_pkg::UNITS_GAP, 1'b0);
            gap_pending = 1'b0;
          end
          if (run < mck_pkg::UNITS_MAX) run = run + 1'b1;
        end else if (run != '0) begin
          add_segment(1'b1, run, 1'b0);
          run         = '0;
          gap_pending = 1'b1;
        end
      end
      if (run != '0) add_segment(1'b1, run, 1'b0);
      add_segment(1'b0, mck_pkg::UNITS_LETTER, 1'b1);
    end
  endfunction

  initial begin
    n_fail    = 0;
    n_pending = 0;
    dot_ms    = mck_pkg::DOT_TIME_RST;
  end

  always @(posedge clk) begin
    segment_t s;
    if (!rst_n) begin
      dot_ms = mck_pkg::DOT_TIME_RST;
      expected_segs.delete();
    end else begin
      // character first, so a same-cycle segment finds its prediction
      if (in_valid && !in_stall) predict_segments(in_character);
      if (out_valid && !out_stall) begin
        if (expected_segs.size() == 0) begin
          $error("segment transfer with none expected");
          n_fail++;
        end else begin
          s = expected_segs.pop_front();
          if (out_led_on !== s.led_on) begin
            $error("led_on: expected %0d, got %0d", s.led_on, out_led_on);
            n_fail++;
          end
          if (out_dot_units !== s.dot_units) begin
            $error("dot_units: expected %0d, got %0d", s.dot_units, out_dot_units);
            n_fail++;
          end
          if (out_duration_ms !== s.duration_ms) begin
            $error("duration_ms: expected %0d, got %0d", s.duration_ms, out_duration_ms);
            n_fail++;
          end
          if (out_last !== s.last) begin
            $error("last: expected %0d, got %0d", s.last, out_last);
            n_fail++;
          end
        end
      end
      if (cfg_we) dot_ms = cfg_wdata;
    end
    n_pending = expected_segs.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the Morse code keyer
// Drives characters and dot time settings, stalls the segment channel at
// random and with one long hold-off, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CODE_BITS    = mck_pkg::CODE_BITS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = CODE_BITS + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 35;
  localparam int N_PHASES     = 6;
  localparam int N_DIRECTED   = 22;

  localparam logic [mck_pkg::CHAR_W-1:0] DIRECTED [N_DIRECTED] = '{
    "A", "Z", "a", "z", "E", "T", "J", "Q", "Y", "O", " ",
    8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, "H", "m", " ", "S"
  };

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [mck_pkg::DOT_W-1:0]   cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic [mck_pkg::CHAR_W-1:0]  in_character;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_led_on;
  logic [mck_pkg::UNITS_W-1:0] out_dot_units;
  logic [mck_pkg::DUR_W-1:0]   out_duration_ms;
  logic                        out_last;

  int fail_count;
  int pending_segs;
  int cycle_count;
  bit idle_on;
  bit hold_req;
  bit hold_done;

  morse_code_keyer #(.CODE_BITS(CODE_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_character(in_character),
    .out_valid(out_valid), .out_stall(out_stall), .out_led_on(out_led_on),
    .out_dot_units(out_dot_units), .out_duration_ms(out_duration_ms),
    .out_last(out_last)
  );

  morse_seg_checker #(.CODE_BITS(CODE_BITS)) seg_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_character(in_character),
    .out_valid(out_valid), .out_stall(out_stall), .out_led_on(out_led_on),
    .out_dot_units(out_dot_units), .out_duration_ms(out_duration_ms),
    .out_last(out_last),
    .n_fail(fail_count), .n_pending(pending_segs)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // segment receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= idle_on ? ($urandom_range(0, 99) < 11) : 1'b0;
      end
    end
  end

  task automatic send_char(input logic [mck_pkg::CHAR_W-1:0] c);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid, wait for every predicted segment, then let the scan finish
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_segs != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_dot_time(input logic [mck_pkg::DOT_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [mck_pkg::DOT_W-1:0]  dot_setting;
    logic [mck_pkg::CHAR_W-1:0] c;
    int                         acting;
    int                         pick;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_character = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at the reset dot time
    for (int i = 0; i < N_DIRECTED; i++) send_char(DIRECTED[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       dot_setting = '0;
        1:       dot_setting = 14'd1;
        2:       dot_setting = '1;
        3:       dot_setting = 14'd10000;
        default: dot_setting = mck_pkg::DOT_W'($urandom);
      endcase
      write_dot_time(dot_setting);
      idle_on = (ph != 3);
      acting  = 0;
      while (acting < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          c = mck_pkg::CHAR_LOWER_A + mck_pkg::CHAR_W'($urandom_range(0, 25));
          if ($urandom_range(0, 1) != 0) c = c - mck_pkg::CHAR_CASE;
          acting++;
        end else if (pick < 85) begin
          c = mck_pkg::CHAR_SPACE;
          acting++;
        end else begin
          c = mck_pkg::CHAR_W'($urandom_range(0, 255));
        end
        // long receiver hold-off while characters keep coming
        if (ph == 1 && acting == 10) hold_req = 1'b1;
        send_char(c);
      end
    end
    idle_on = 1'b1;

    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
